### design/usd_pkg.sv
// usd_pkg: types, constants and helper functions for the URL setting decoder.
// No dependencies; compiled first.
`default_nettype none

package usd_pkg;

  localparam int BYTE_W   = 8;
  localparam int NIBBLE_W = 4;

  // Characters with a meaning to the decoder
  localparam logic [BYTE_W-1:0] CHR_PERCENT = 8'h25;  // '%'
  localparam logic [BYTE_W-1:0] CHR_PLUS    = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CHR_EQUALS  = 8'h3D;  // '='
  localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'h20;  // ' '
  localparam logic [BYTE_W-1:0] PRINT_LO    = 8'h20;  // first printable
  localparam logic [BYTE_W-1:0] PRINT_END   = 8'h7F;  // first past printable

  // Escape sequencer, one-hot
  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HIGH = 3'b010,
    ESC_LOW  = 3'b100
  } usd_esc_t;

  // Decoder state carried from one item to the next
  typedef struct packed {
    usd_esc_t              esc;
    logic [NIBBLE_W-1:0]   high_nibble;
    logic                  stop_seen;
    logic                  equals_seen;
  } usd_state_t;

  localparam usd_state_t STATE_RESET = '{
    esc:         ESC_IDLE,
    high_nibble: '0,
    stop_seen:   1'b0,
    equals_seen: 1'b0
  };

  // One result item
  typedef struct packed {
    logic              has_byte;
    logic [BYTE_W-1:0] out_byte;
    logic              is_separator;
    logic              in_value_part;
    logic              stopped;
    logic              end_mark;
  } usd_result_t;

  // Hex digit value, either case; anything else counts as zero
  function automatic logic [NIBBLE_W-1:0] hex_digit(input logic [BYTE_W-1:0] b);
    logic [NIBBLE_W-1:0] d;
    d = '0;
    if (b inside {[8'h30:8'h39]}) begin
      d = b[NIBBLE_W-1:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      d = b[NIBBLE_W-1:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### design/usd_if.sv
// usd_in_if / usd_out_if: valid-ready channels for raw and decoded items.
// Depends on usd_pkg.
`default_nettype none

interface usd_in_if;
  import usd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface usd_out_if;
  import usd_pkg::*;
  logic              valid;
  logic              ready;
  logic              has_byte;
  logic [BYTE_W-1:0] out_byte;
  logic              is_separator;
  logic              in_value_part;
  logic              stopped;
  logic              end_mark;

  modport source (output valid, output has_byte, output out_byte, output is_separator,
                  output in_value_part, output stopped, output end_mark, input ready);
  modport sink   (input valid, input has_byte, input out_byte, input is_separator,
                  input in_value_part, input stopped, input end_mark, output ready);
endinterface

`default_nettype wire

### design/usd_decode.sv
// usd_decode: per-item decode logic, state in to next state and result out.
// Purely combinational; depends on usd_pkg.
`default_nettype none

module usd_decode (
  input  usd_pkg::usd_state_t            state,
  input  logic [usd_pkg::BYTE_W-1:0]     raw_byte,
  input  logic                           last,
  output usd_pkg::usd_state_t            state_nxt,
  output usd_pkg::usd_result_t           result
);
  import usd_pkg::*;

  logic              have;
  logic [BYTE_W-1:0] dec;
  logic [BYTE_W-1:0] mapped;
  logic [NIBBLE_W-1:0] digit;
  usd_state_t        upd;

  assign digit = hex_digit(raw_byte);

  always_comb begin
    upd    = state;
    have   = 1'b0;
    dec    = '0;
    mapped = '0;
    result = '0;

    // Escape sequencing
    case (state.esc)
      ESC_HIGH: begin
        upd.high_nibble = digit;
        if (last) begin
          dec  = {digit, {NIBBLE_W{1'b0}}};
          have = 1'b1;
          upd.esc = ESC_IDLE;
        end else begin
          upd.esc = ESC_LOW;
        end
      end
      ESC_LOW: begin
        dec  = {state.high_nibble, digit};
        have = 1'b1;
        upd.esc = ESC_IDLE;
      end
      default: begin
        upd.esc = ESC_IDLE;
        if (raw_byte == CHR_PERCENT) begin
          // a lone final '%' decodes to zero
          if (last) begin
            have = 1'b1;
          end else begin
            upd.esc = ESC_HIGH;
          end
        end else begin
          dec  = raw_byte;
          have = 1'b1;
        end
      end
    endcase

    // Plus to space, printable check, separator tracking
    mapped = (dec == CHR_PLUS) ? CHR_SPACE : dec;
    if (have && !state.stop_seen) begin
      if (mapped < PRINT_LO || mapped >= PRINT_END) begin
        upd.stop_seen = 1'b1;
      end else begin
        result.has_byte      = 1'b1;
        result.out_byte      = mapped;
        result.in_value_part = state.equals_seen;
        if (mapped == CHR_EQUALS && !state.equals_seen) begin
          result.is_separator = 1'b1;
          upd.equals_seen     = 1'b1;
        end
      end
    end
    result.stopped  = upd.stop_seen;
    result.end_mark = last;

    // Setting ends: back to the reset state
    state_nxt = last ? STATE_RESET : upd;
  end

endmodule

`default_nettype wire

### design/url_setting_decoder.sv
// url_setting_decoder: URL percent-decoder for one name=value setting.
// Depends on usd_pkg, usd_if (usd_in_if, usd_out_if) and usd_decode.
//
// Usage:
//   in_ch carries one raw byte of the encoded setting per item, with
//   final_byte set on the last byte. out_ch gives exactly one result item
//   per input item, in order: a decoded printable byte when has_byte is set,
//   plus the separator, value, stop and end flags.
// Path: an accepted item is held in the input register and is decoded out of
//   it into the result register when it advances.
// Throughput: one item per cycle while out_ch is not stalled; the decode is a
//   single pass of shallow logic between the input and result registers, and
//   the escape state is updated as the item leaves the input register.
// Reset: rst_n (synchronous, active low) empties both registers and returns
//   the decoder to idle, outside any escape, no '=' and no stop seen.
//   The state also returns there after every item marked final_byte.
// Stall: when out_ch.ready is low the result is held; the input register
//   still takes one more item, and in_ch.ready drops only when both stages
//   are full.
`default_nettype none

module url_setting_decoder (
  input  logic             clk,
  input  logic             rst_n,
  usd_in_if.sink           in_ch,
  usd_out_if.source        out_ch
);
  import usd_pkg::*;

  // Input register
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_final_r;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  usd_result_t       result_r;
  usd_result_t       result_nxt;

  // Decoder state
  usd_state_t        state_r;
  usd_state_t        state_nxt;

  logic              advance;
  logic              in_take;

  // Stage handshakes
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  // Decode one item
  usd_decode u_decode (
    .state     (state_r),
    .raw_byte  (in_byte_r),
    .last      (in_final_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_ch.in_byte;
      in_final_r <= in_ch.final_byte;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  // Result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.has_byte      = result_r.has_byte;
  assign out_ch.out_byte      = result_r.out_byte;
  assign out_ch.is_separator  = result_r.is_separator;
  assign out_ch.in_value_part = result_r.in_value_part;
  assign out_ch.stopped       = result_r.stopped;
  assign out_ch.end_mark      = result_r.end_mark;

endmodule

`default_nettype wire

### design/usd_checker.sv
// usd_checker: port-level assertions for url_setting_decoder, and its bind.
// Depends on usd_pkg and url_setting_decoder.
`default_nettype none

module usd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       has_byte,
  input  logic [usd_pkg::BYTE_W-1:0] out_byte,
  input  logic                       is_separator,
  input  logic                       in_value_part,
  input  logic                       stopped
);
  import usd_pkg::*;

  // A stalled result keeps its valid and its byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(has_byte)))
    else $error("result item changed while stalled");

  // No flags and a zero byte when nothing is delivered
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !has_byte) |-> (out_byte == '0 && !is_separator && !in_value_part))
    else $error("empty result carries data");

  // A delivered byte is printable, never a raw plus, and never after a stop
  a_byte_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && has_byte) |-> (out_byte >= PRINT_LO && out_byte < PRINT_END &&
                                 out_byte != CHR_PLUS && !stopped))
    else $error("delivered byte out of range");

  // The separator is an '=' and is not itself part of the value
  a_separator: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && is_separator) |-> (has_byte && out_byte == CHR_EQUALS && !in_value_part))
    else $error("bad separator flag");

endmodule

bind url_setting_decoder usd_checker u_usd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .has_byte      (out_ch.has_byte),
  .out_byte      (out_ch.out_byte),
  .is_separator  (out_ch.is_separator),
  .in_value_part (out_ch.in_value_part),
  .stopped       (out_ch.stopped)
);

`default_nettype wire
